/* rtl/core/bved_pkg.sv */
`default_nettype none

package bved_pkg;

    localparam int MAX_READ_LENGTH = 256;
    localparam int MAX_THRESHOLD   = 15;
    localparam int ALPHABET        = 5;
    localparam int QUEUE_DEPTH     = 2;

    localparam int THR_W  = 4;
    localparam int BASE_W = 3;
    localparam int DIST_W = 5;
    localparam int POS_W  = 9;

    typedef enum logic [1:0] {
        K_PRELOAD,
        K_STEP,
        K_LAST
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BASE_W-1:0] ref_base;
        logic [BASE_W-1:0] read_base;
    } t_item;

endpackage

`default_nettype wire

/* rtl/core/bved_front.sv */
`default_nettype none

module bved_front #(
    parameter int QUEUE_DEPTH = bved_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_action,
    input  logic [bved_pkg::BASE_W-1:0] i_ref_base,
    input  logic [bved_pkg::BASE_W-1:0] i_read_base,
    input  logic                        i_last,
    output bved_pkg::t_item             o_item,
    output logic                        o_item_valid,
    input  logic                        i_item_pop
);
    import bved_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  n_wr;
    logic [PW-1:0]  n_rd;
    t_item          item;
    logic           push;
    logic           pop;

    // classify: last only counts on a step
    always_comb begin
        item.ref_base  = i_ref_base;
        item.read_base = i_read_base;
        if (!i_action) begin
            item.kind = K_PRELOAD;
        end else if (i_last) begin
            item.kind = K_LAST;
        end else begin
            item.kind = K_STEP;
        end
    end

    assign o_stall      = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign push         = i_valid && !o_stall;
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_mem[r_rd];
    assign n_wr         = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd         = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= n_wr;
            end
            if (pop) begin
                r_rd <= n_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bved_back.sv */
`default_nettype none

module bved_back #(
    parameter int MAX_READ_LENGTH = bved_pkg::MAX_READ_LENGTH,
    parameter int ALPHABET        = bved_pkg::ALPHABET
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bved_pkg::THR_W-1:0]  i_max_errors,
    input  bved_pkg::t_item             i_item,
    input  logic                        i_item_valid,
    output logic                        o_item_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bved_pkg::DIST_W-1:0] o_distance,
    output logic                        o_found,
    output logic [bved_pkg::POS_W-1:0]  o_end_position
);
    import bved_pkg::*;

    localparam int VW  = 2 * MAX_THRESHOLD + 1;
    localparam int IW  = $clog2(VW);
    localparam int ECW = $clog2(3 * MAX_THRESHOLD + 2);
    localparam int SW  = ECW + 2;
    localparam int RCW = $clog2(MAX_READ_LENGTH + 1);

    typedef enum logic {
        S_RUN,
        S_SCAN
    } t_state;

    t_state                r_state;
    logic [VW-1:0]         r_mask [ALPHABET];
    logic [VW-1:0]         r_vp;
    logic [VW-1:0]         r_vn;
    logic [ECW-1:0]        r_cnt;
    logic [RCW-1:0]        r_rc;
    logic                  r_stop;
    logic signed [SW-1:0]  r_cur;
    logic [DIST_W-1:0]     r_best;
    logic                  r_hit;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      r_walk;
    logic [IW-1:0]         r_idx;
    logic                  r_out_valid;
    logic [DIST_W-1:0]     r_distance;
    logic                  r_found;
    logic [POS_W-1:0]      r_end;

    logic [VW-1:0]         m_new [ALPHABET];
    logic [VW-1:0]         top;
    logic [VW-1:0]         eq;
    logic [VW-1:0]         x;
    logic [VW-1:0]         d0;
    logic [VW-1:0]         hn;
    logic [VW-1:0]         hp;
    logic [VW-1:0]         xs;
    logic [VW-1:0]         n_vp;
    logic [VW-1:0]         n_vn;
    logic [ECW-1:0]        n_cnt;
    logic [ECW-1:0]        cnt_inc;
    logic [ECW-1:0]        thr3;
    logic                  n_stop;
    logic [RCW-1:0]        n_rc;
    logic [POS_W-1:0]      site;
    logic                  init_hit;
    logic [DIST_W-1:0]     limit;
    logic [DIST_W-1:0]     init_best;
    logic signed [SW-1:0]  cur_next;
    logic signed [SW-1:0]  e_s;
    logic signed [SW-1:0]  best_s;
    logic [POS_W-1:0]      walk_next;
    logic                  better;
    logic                  done;
    logic                  out_free;
    logic                  finish;

    // band top bit and shifted masks
    always_comb begin
        top = VW'(1) << {i_max_errors, 1'b0};
        eq  = '0;
        for (int a = 0; a < ALPHABET; a++) begin
            m_new[a] = (r_mask[a] >> 1) | ((int'(i_item.ref_base) == a) ? top : '0);
            if (int'(i_item.read_base) == a) begin
                eq = m_new[a];
            end
        end
    end

    // vector update for one read base
    always_comb begin
        x       = eq | r_vn;
        d0      = ((r_vp + (x & r_vp)) ^ r_vp) | x;
        hn      = r_vp & d0;
        hp      = r_vn | ~(r_vp | d0);
        xs      = d0 >> 1;
        cnt_inc = r_cnt + 1'b1;
        thr3    = ECW'({i_max_errors, 1'b0}) + ECW'(i_max_errors);
        n_vp    = r_vp;
        n_vn    = r_vn;
        n_cnt   = r_cnt;
        n_stop  = r_stop;
        if (!r_stop) begin
            n_vn = xs & hp;
            n_vp = hn | ~(xs | hp);
            if (!d0[0]) begin
                n_cnt  = cnt_inc;
                n_stop = (cnt_inc > thr3);
            end
        end
        n_rc      = (r_rc < RCW'(MAX_READ_LENGTH)) ? r_rc + 1'b1 : r_rc;
        site      = POS_W'(n_rc - 1'b1);
        limit     = DIST_W'({1'b0, i_max_errors}) + DIST_W'(1);
        init_hit  = !n_stop && (n_cnt <= ECW'(i_max_errors));
        init_best = init_hit ? DIST_W'(n_cnt) : limit;
    end

    // one band bit per scan cycle
    always_comb begin
        e_s       = SW'(i_max_errors);
        best_s    = SW'(r_best);
        cur_next  = r_cur + SW'(r_vp[0]) - SW'(r_vn[0]);
        walk_next = r_walk + 1'b1;
        better    = !cur_next[SW-1] && (cur_next <= e_s) && (cur_next < best_s);
        done      = r_stop || (r_idx == IW'({i_max_errors, 1'b0}));
        out_free  = !r_out_valid || !i_stall;
        finish    = (r_state == S_SCAN) && done && out_free;
    end

    assign o_item_pop     = i_item_valid && (r_state == S_RUN);
    assign o_valid        = r_out_valid;
    assign o_distance     = r_distance;
    assign o_found        = r_found;
    assign o_end_position = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_mask      <= '{default: '0};
            r_vp        <= '0;
            r_vn        <= '0;
            r_cnt       <= '0;
            r_rc        <= '0;
            r_stop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && !finish) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_RUN: begin
                    if (o_item_pop) begin
                        unique case (i_item.kind)
                            K_PRELOAD: begin
                                r_mask <= m_new;
                            end
                            K_STEP: begin
                                r_mask <= m_new;
                                r_vp   <= n_vp;
                                r_vn   <= n_vn;
                                r_cnt  <= n_cnt;
                                r_stop <= n_stop;
                                r_rc   <= n_rc;
                            end
                            K_LAST: begin
                                r_mask  <= '{default: '0};
                                r_vp    <= n_vp;
                                r_vn    <= n_vn;
                                r_cnt   <= n_cnt;
                                r_stop  <= n_stop;
                                r_rc    <= n_rc;
                                r_cur   <= SW'(n_cnt);
                                r_best  <= init_best;
                                r_hit   <= init_hit;
                                r_pos   <= site;
                                r_walk  <= site;
                                r_idx   <= '0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (done) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_distance  <= r_best;
                            r_found     <= r_hit;
                            r_end       <= r_hit ? r_pos : '0;
                            r_vp        <= '0;
                            r_vn        <= '0;
                            r_cnt       <= '0;
                            r_rc        <= '0;
                            r_stop      <= 1'b0;
                            r_state     <= S_RUN;
                        end
                    end else begin
                        r_cur  <= cur_next;
                        r_vp   <= r_vp >> 1;
                        r_vn   <= r_vn >> 1;
                        r_idx  <= r_idx + 1'b1;
                        r_walk <= walk_next;
                        if (better) begin
                            r_best <= DIST_W'(cur_next);
                            r_pos  <= walk_next;
                            r_hit  <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_item_pop)
        else $error("item taken during band scan");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= IW'({i_max_errors, 1'b0})))
        else $error("scan index past band");

    a_found_within: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_found) |-> (r_distance <= {1'b0, i_max_errors}))
        else $error("found result above threshold");

    a_miss_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |->
        (r_end == '0 && r_distance == ({1'b0, i_max_errors} + DIST_W'(1))))
        else $error("miss result malformed");

    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_out_valid && r_vp == '0 && r_cnt == '0 && !r_stop))
        else $error("state not cleared after result");
`endif

endmodule

`default_nettype wire

/* rtl/core/banded_bitvector_edit_distance.sv */
`default_nettype none

// channel    direction  handshake              payload
// input      in         i_valid / o_stall      i_action, i_ref_base, i_read_base, i_last
// result     out        o_valid / i_stall      o_distance, o_found, o_end_position
// config     in         i_cfg_valid / o_cfg_ready  i_max_errors
//
// preload and step items run one per cycle through a small queue into the engine while it
// is not scanning; a last step is one update, a scan at one band bit per cycle, then a load
// of the result register once the output is free (the scan ends early after a stop)
// reset clears masks, vectors, counters and the queue; max_errors returns to 3
// a stalled result holds in its register while later items keep being taken

module banded_bitvector_edit_distance #(
    parameter int MAX_READ_LENGTH = bved_pkg::MAX_READ_LENGTH,
    parameter int ALPHABET        = bved_pkg::ALPHABET,
    parameter int QUEUE_DEPTH     = bved_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_action,
    input  logic [bved_pkg::BASE_W-1:0] i_ref_base,
    input  logic [bved_pkg::BASE_W-1:0] i_read_base,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bved_pkg::DIST_W-1:0] o_distance,
    output logic                        o_found,
    output logic [bved_pkg::POS_W-1:0]  o_end_position,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bved_pkg::THR_W-1:0]  i_max_errors
);
    import bved_pkg::*;

    logic [THR_W-1:0] r_max_errors;
    t_item            item;
    logic             item_valid;
    logic             item_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_errors <= THR_W'(3);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_errors <= i_max_errors;
        end
    end

    bved_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_ref_base   (i_ref_base),
        .i_read_base  (i_read_base),
        .i_last       (i_last),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_pop   (item_pop)
    );

    bved_back #(
        .MAX_READ_LENGTH (MAX_READ_LENGTH),
        .ALPHABET        (ALPHABET)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_max_errors   (r_max_errors),
        .i_item         (item),
        .i_item_valid   (item_valid),
        .o_item_pop     (item_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_distance     (o_distance),
        .o_found        (o_found),
        .o_end_position (o_end_position)
    );

endmodule

`default_nettype wire
